>>> design/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition at one edge leads to a consequence at the next edge.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> design/oamu_pkg.sv
// Types and constants shared by the operand addressing mode unit.
`default_nettype none

package oamu_pkg;

   // Actions of a request item.
   localparam logic [1:0] ACT_DECODE    = 2'd0;
   localparam logic [1:0] ACT_WRITE_REG = 2'd1;
   localparam logic [1:0] ACT_WRITE_MEM = 2'd2;
   localparam logic [1:0] ACT_READ_REG  = 2'd3;

   // Operand formats.
   localparam logic [2:0] FMT_SSDD   = 3'd0;
   localparam logic [2:0] FMT_DD     = 3'd1;
   localparam logic [2:0] FMT_BRANCH = 3'd2;
   localparam logic [2:0] FMT_REG_SS = 3'd3;
   localparam logic [2:0] FMT_REG_DD = 3'd4;
   localparam logic [2:0] FMT_REG    = 3'd5;

   // Register addressing modes.
   localparam logic [2:0] MODE_REG       = 3'd0;
   localparam logic [2:0] MODE_REG_DEF   = 3'd1;
   localparam logic [2:0] MODE_AINC      = 3'd2;
   localparam logic [2:0] MODE_AINC_DEF  = 3'd3;
   localparam logic [2:0] MODE_ADEC      = 3'd4;
   localparam logic [2:0] MODE_ADEC_DEF  = 3'd5;
   localparam logic [2:0] MODE_INDEX     = 3'd6;
   localparam logic [2:0] MODE_INDEX_DEF = 3'd7;

   // Register used as the instruction pointer for index words.
   localparam logic [2:0] PC_REG = 3'd7;
   // First register that always steps by a full word.
   localparam logic [2:0] WORD_STEP_REG = 3'd6;

   // Which part of the opcode describes the operand in work.
   localparam logic [1:0] FLD_HIGH  = 2'd0; // mode and register in bits 11..6
   localparam logic [1:0] FLD_LOW   = 2'd1; // mode and register in bits 5..0
   localparam logic [1:0] FLD_REGHI = 2'd2; // register in bits 8..6, register mode
   localparam logic [1:0] FLD_REGLO = 2'd3; // register in bits 2..0, register mode

   // Datapath operations.
   localparam logic [3:0] DP_NOP        = 4'd0;
   localparam logic [3:0] DP_REG_WRITE  = 4'd1;
   localparam logic [3:0] DP_REG_READ   = 4'd2;
   localparam logic [3:0] DP_MEM_WRITE  = 4'd3;
   localparam logic [3:0] DP_BRANCH     = 4'd4;
   localparam logic [3:0] DP_OPND_START = 4'd5;
   localparam logic [3:0] DP_MEM_READ   = 4'd6;
   localparam logic [3:0] DP_INDEX      = 4'd7;
   localparam logic [3:0] DP_OPND_DATA  = 4'd8;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] opcode;
      logic [2:0]  instr_format;
      logic        byte_mode;
      logic [2:0]  target_register;
      logic [15:0] write_address;
      logic [15:0] write_value;
   } req_item_type;

   typedef struct packed {
      logic        src_is_memory;
      logic [15:0] src_location;
      logic        dst_is_memory;
      logic [15:0] dst_location;
      logic [7:0]  branch_offset;
      logic [15:0] read_value;
   } rsp_item_type;

   typedef struct packed {
      logic        is_mem;
      logic [15:0] loc;
   } operand_type;

   typedef struct packed {
      logic       load;
      logic       publish;
      logic [3:0] op;
      logic [1:0] fld;
      logic       to_dst;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] instr_format;
      logic [2:0] mode;
   } dp_status_type;

endpackage

`default_nettype wire

>>> design/oamu_if.sv
// Handshake channel interfaces for the request and response sides.
`default_nettype none

interface oamu_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] opcode;
   logic [2:0]  instr_format;
   logic        byte_mode;
   logic [2:0]  target_register;
   logic [15:0] write_address;
   logic [15:0] write_value;

   modport source (output valid, action, opcode, instr_format, byte_mode, target_register,
                   write_address, write_value, input ready);
   modport sink (input valid, action, opcode, instr_format, byte_mode, target_register,
                 write_address, write_value, output ready);
endinterface

interface oamu_rsp_if;
   logic        valid;
   logic        ready;
   logic        src_is_memory;
   logic [15:0] src_location;
   logic        dst_is_memory;
   logic [15:0] dst_location;
   logic [7:0]  branch_offset;
   logic [15:0] read_value;

   modport source (output valid, src_is_memory, src_location, dst_is_memory, dst_location,
                   branch_offset, read_value, input ready);
   modport sink (input valid, src_is_memory, src_location, dst_is_memory, dst_location,
                 branch_offset, read_value, output ready);
endinterface

`default_nettype wire

>>> design/operand_addressing_mode_unit.sv
// Operand addressing mode unit: top level joining controller, datapath and data memory.
//
// One request channel carries an action with its fields: decode an instruction's
// operands, write a register, write a memory word, or read a register. Every
// accepted request gives exactly one response with the held source and
// destination operands (register number or effective address), the held branch
// offset, and the register contents for a register read (zero otherwise).
// Requests are taken one at a time; ready is high only while the controller idles.
// Register and memory writes and register reads pass through the dispatch and
// finish states to the response. A decode resolves each operand in turn: a
// register mode or a plain step mode in the operand state alone, a deferred step
// mode with one read of the single data memory port, index mode with a read of
// the index word, and index deferred mode with a read of the index word and then
// of the operand word. The next request is taken in the cycle after a response
// is loaded.
// Reset clears the register file, the held operands and branch offset, and the
// response valid flag; the data memory is not cleared and must be written
// before it is read. A stalled response stays in the output register while the
// next request is worked on; that request then waits before its own response.
`default_nettype none

module operand_addressing_mode_unit
   import oamu_pkg::*;
#(
   parameter int MEMORY_WORDS = 4096
) (
   input  wire logic   clock,
   input  wire logic   reset,
   oamu_req_if.sink    req_chan,
   oamu_rsp_if.source  rsp_chan
);

   localparam int AW = $clog2(MEMORY_WORDS);

   req_item_type  req_item;
   rsp_item_type  rsp_item;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic          ram_en;
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [15:0]   ram_wdata;
   logic [15:0]   ram_rdata;

   assign req_item.action          = req_chan.action;
   assign req_item.opcode          = req_chan.opcode;
   assign req_item.instr_format    = req_chan.instr_format;
   assign req_item.byte_mode       = req_chan.byte_mode;
   assign req_item.target_register = req_chan.target_register;
   assign req_item.write_address   = req_chan.write_address;
   assign req_item.write_value     = req_chan.write_value;

   oamu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   oamu_dp #(
      .MEMORY_WORDS (MEMORY_WORDS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .ram_en    (ram_en),
      .ram_we    (ram_we),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata),
      .rsp_item  (rsp_item)
   );

   oamu_ram #(
      .WIDTH (16),
      .DEPTH (MEMORY_WORDS)
   ) u_data_mem (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rsp_chan.src_is_memory = rsp_item.src_is_memory;
   assign rsp_chan.src_location  = rsp_item.src_location;
   assign rsp_chan.dst_is_memory = rsp_item.dst_is_memory;
   assign rsp_chan.dst_location  = rsp_item.dst_location;
   assign rsp_chan.branch_offset = rsp_item.branch_offset;
   assign rsp_chan.read_value    = rsp_item.read_value;

endmodule

`default_nettype wire

>>> design/oamu_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module oamu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> design/oamu_ctrl.sv
// Controller state machine that sequences actions and operand resolution.
`default_nettype none

module oamu_ctrl
   import oamu_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   localparam logic [2:0] S_IDLE       = 3'd0;
   localparam logic [2:0] S_DISPATCH   = 3'd1;
   localparam logic [2:0] S_OPND       = 3'd2;
   localparam logic [2:0] S_IDX_ISSUE  = 3'd3;
   localparam logic [2:0] S_IDX_DATA   = 3'd4;
   localparam logic [2:0] S_OPND_ISSUE = 3'd5;
   localparam logic [2:0] S_OPND_DATA  = 3'd6;
   localparam logic [2:0] S_FINISH     = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       second_ff, second_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] fld;
   logic       to_dst;
   logic       has_second;
   logic       opnd_done;

   // Operand order per format: the first operand is always resolved completely
   // before the second, since both may step the same registers.
   always_comb begin
      fld        = FLD_LOW;
      to_dst     = 1'b1;
      has_second = 1'b0;
      case (status.instr_format)
         FMT_SSDD: begin
            fld        = second_ff ? FLD_LOW : FLD_HIGH;
            to_dst     = second_ff;
            has_second = 1'b1;
         end
         FMT_REG_SS: begin
            fld        = second_ff ? FLD_REGHI : FLD_LOW;
            to_dst     = second_ff;
            has_second = 1'b1;
         end
         FMT_REG_DD: begin
            fld        = second_ff ? FLD_LOW : FLD_REGHI;
            to_dst     = second_ff;
            has_second = 1'b1;
         end
         FMT_REG: begin
            fld = FLD_REGLO;
         end
         default: begin
            fld = FLD_LOW;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      second_in   = second_ff;
      opnd_done   = 1'b0;
      cmd         = '0;
      cmd.op      = DP_NOP;
      cmd.fld     = fld;
      cmd.to_dst  = to_dst;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load  = 1'b1;
               second_in = 1'b0;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_FINISH;
            case (status.action)
               ACT_DECODE: begin
                  case (status.instr_format)
                     FMT_SSDD, FMT_DD, FMT_REG_SS, FMT_REG_DD, FMT_REG: begin
                        state_in = S_OPND;
                     end
                     FMT_BRANCH: begin
                        cmd.op = DP_BRANCH;
                     end
                     default: begin
                        cmd.op = DP_NOP;
                     end
                  endcase
               end
               ACT_WRITE_REG: cmd.op = DP_REG_WRITE;
               ACT_WRITE_MEM: cmd.op = DP_MEM_WRITE;
               ACT_READ_REG:  cmd.op = DP_REG_READ;
               default:       cmd.op = DP_NOP;
            endcase
         end
         S_OPND: begin
            cmd.op = DP_OPND_START;
            case (status.mode)
               MODE_AINC_DEF, MODE_ADEC_DEF: state_in = S_OPND_ISSUE;
               MODE_INDEX, MODE_INDEX_DEF:   state_in = S_IDX_ISSUE;
               default:                      opnd_done = 1'b1;
            endcase
         end
         S_IDX_ISSUE: begin
            cmd.op   = DP_MEM_READ;
            state_in = S_IDX_DATA;
         end
         S_IDX_DATA: begin
            cmd.op = DP_INDEX;
            if (status.mode == MODE_INDEX) begin
               opnd_done = 1'b1;
            end else begin
               state_in = S_OPND_ISSUE;
            end
         end
         S_OPND_ISSUE: begin
            cmd.op   = DP_MEM_READ;
            state_in = S_OPND_DATA;
         end
         S_OPND_DATA: begin
            cmd.op    = DP_OPND_DATA;
            opnd_done = 1'b1;
         end
         S_FINISH: begin
            // The output register is free or is emptied in this cycle.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (opnd_done) begin
         if (has_second && !second_ff) begin
            second_in = 1'b1;
            state_in  = S_OPND;
         end else begin
            state_in = S_FINISH;
         end
      end
   end

   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> design/oamu_dp.sv
// Datapath: register file, operand registers, address forming and output register.
`default_nettype none

module oamu_dp
   import oamu_pkg::*;
#(
   parameter int MEMORY_WORDS = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire req_item_type                    req_item,
   input  wire dp_cmd_type                      cmd,
   output dp_status_type                        status,
   output logic                                 ram_en,
   output logic                                 ram_we,
   output logic [$clog2(MEMORY_WORDS)-1:0]      ram_addr,
   output logic [15:0]                          ram_wdata,
   input  wire logic [15:0]                     ram_rdata,
   output rsp_item_type                         rsp_item
);

   localparam int AW = $clog2(MEMORY_WORDS);
   // The word index has 15 bits and the memory at least 256 words, so the
   // quotient fits in seven bits.
   localparam int SLOT_STEPS = 7;
   localparam int REM_W = 15 + SLOT_STEPS + 1;
   localparam logic [REM_W-1:0] WORDS_W = REM_W'(MEMORY_WORDS);

   // Word index of a byte address, wrapped at the memory size by restoring
   // subtraction of shifted copies of the size.
   function automatic logic [AW-1:0] mem_slot(input logic [15:0] byte_addr);
      logic [REM_W-1:0] rem;
      rem = {{(REM_W-15){1'b0}}, byte_addr[15:1]};
      for (int k = SLOT_STEPS - 1; k >= 0; k--) begin
         if (rem >= (WORDS_W << k)) begin
            rem = rem - (WORDS_W << k);
         end
      end
      return rem[AW-1:0];
   endfunction

   req_item_type item_ff;
   logic [15:0]  regs_ff [8];
   logic [15:0]  addr_ff, addr_in;
   operand_type  src_ff, dst_ff;
   logic [7:0]   branch_ff, branch_in;
   logic [15:0]  rv_ff, rv_in;
   rsp_item_type rsp_ff;

   logic [2:0]   cur_reg;
   logic [2:0]   cur_mode;
   logic [15:0]  step;
   logic [2:0]   rd_sel;
   logic [15:0]  rd_val;
   logic         wr_en;
   logic [2:0]   wr_sel;
   logic [15:0]  wr_val;
   logic         res_en;
   operand_type  res_val;
   logic [15:0]  sum;

   always_comb begin
      case (cmd.fld)
         FLD_HIGH: begin
            cur_reg  = item_ff.opcode[8:6];
            cur_mode = item_ff.opcode[11:9];
         end
         FLD_LOW: begin
            cur_reg  = item_ff.opcode[2:0];
            cur_mode = item_ff.opcode[5:3];
         end
         FLD_REGHI: begin
            cur_reg  = item_ff.opcode[8:6];
            cur_mode = MODE_REG;
         end
         default: begin
            cur_reg  = item_ff.opcode[2:0];
            cur_mode = MODE_REG;
         end
      endcase
   end

   // Byte steps apply to the general registers only; the stack pointer and
   // the instruction pointer always move by a word.
   assign step = (item_ff.byte_mode && (cur_reg < WORD_STEP_REG)) ? 16'd1 : 16'd2;

   always_comb begin
      if (cmd.op == DP_REG_READ) begin
         rd_sel = item_ff.target_register;
      end else if ((cmd.op == DP_OPND_START) &&
                   ((cur_mode == MODE_INDEX) || (cur_mode == MODE_INDEX_DEF))) begin
         rd_sel = PC_REG;
      end else begin
         rd_sel = cur_reg;
      end
   end

   assign rd_val = regs_ff[rd_sel];
   assign sum    = rd_val + ram_rdata;

   always_comb begin
      wr_en       = 1'b0;
      wr_sel      = cur_reg;
      wr_val      = rd_val;
      res_en      = 1'b0;
      res_val     = '0;
      addr_in     = addr_ff;
      branch_in   = branch_ff;
      rv_in       = rv_ff;
      ram_en      = 1'b0;
      ram_we      = 1'b0;
      ram_addr    = mem_slot(addr_ff);
      ram_wdata   = item_ff.write_value;
      case (cmd.op)
         DP_REG_WRITE: begin
            wr_en  = 1'b1;
            wr_sel = item_ff.target_register;
            wr_val = item_ff.write_value;
         end
         DP_REG_READ: begin
            rv_in = rd_val;
         end
         DP_MEM_WRITE: begin
            ram_en = 1'b1;
            ram_we = 1'b1;
         end
         DP_BRANCH: begin
            branch_in = item_ff.opcode[7:0];
         end
         DP_OPND_START: begin
            case (cur_mode)
               MODE_REG: begin
                  res_en      = 1'b1;
                  res_val.loc = {13'd0, cur_reg};
               end
               MODE_REG_DEF: begin
                  res_en         = 1'b1;
                  res_val.is_mem = 1'b1;
                  res_val.loc    = rd_val;
               end
               MODE_AINC: begin
                  res_en         = 1'b1;
                  res_val.is_mem = 1'b1;
                  res_val.loc    = rd_val;
                  wr_en          = 1'b1;
                  wr_val         = rd_val + step;
               end
               MODE_AINC_DEF: begin
                  addr_in = rd_val;
                  wr_en   = 1'b1;
                  wr_val  = rd_val + 16'd2;
               end
               MODE_ADEC: begin
                  wr_en          = 1'b1;
                  wr_val         = rd_val - step;
                  res_en         = 1'b1;
                  res_val.is_mem = 1'b1;
                  res_val.loc    = wr_val;
               end
               MODE_ADEC_DEF: begin
                  wr_en   = 1'b1;
                  wr_val  = rd_val - 16'd2;
                  addr_in = wr_val;
               end
               default: begin
                  // Both index modes fetch the index word at the instruction pointer.
                  addr_in = rd_val;
                  wr_en   = 1'b1;
                  wr_sel  = PC_REG;
                  wr_val  = rd_val + 16'd2;
               end
            endcase
         end
         DP_MEM_READ: begin
            ram_en = 1'b1;
         end
         DP_INDEX: begin
            if (cur_mode == MODE_INDEX) begin
               res_en         = 1'b1;
               res_val.is_mem = 1'b1;
               res_val.loc    = sum;
            end else begin
               addr_in = sum;
            end
         end
         DP_OPND_DATA: begin
            res_en         = 1'b1;
            res_val.is_mem = 1'b1;
            res_val.loc    = ram_rdata;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_item;
         addr_ff <= req_item.write_address;
         rv_ff   <= 16'd0;
      end else begin
         addr_ff <= addr_in;
         rv_ff   <= rv_in;
      end
      if (cmd.publish) begin
         rsp_ff.src_is_memory <= src_ff.is_mem;
         rsp_ff.src_location  <= src_ff.loc;
         rsp_ff.dst_is_memory <= dst_ff.is_mem;
         rsp_ff.dst_location  <= dst_ff.loc;
         rsp_ff.branch_offset <= branch_ff;
         rsp_ff.read_value    <= rv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            regs_ff[i] <= 16'd0;
         end
         src_ff    <= '0;
         dst_ff    <= '0;
         branch_ff <= 8'd0;
      end else begin
         if (wr_en) begin
            regs_ff[wr_sel] <= wr_val;
         end
         if (res_en && !cmd.to_dst) begin
            src_ff <= res_val;
         end
         if (res_en && cmd.to_dst) begin
            dst_ff <= res_val;
         end
         branch_ff <= branch_in;
      end
   end

   assign status.action       = item_ff.action;
   assign status.instr_format = item_ff.instr_format;
   assign status.mode         = cur_mode;
   assign rsp_item            = rsp_ff;

endmodule

`default_nettype wire

>>> design/oamu_chk.sv
// Port-level checker for the operand addressing mode unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module oamu_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_src_is_memory,
   input wire logic [15:0] rsp_src_location,
   input wire logic        rsp_dst_is_memory,
   input wire logic [15:0] rsp_dst_location,
   input wire logic [7:0]  rsp_branch_offset,
   input wire logic [15:0] rsp_read_value
);

   // A stalled response keeps its valid flag.
   `ASSERT_NEXT(rsp_valid_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response valid dropped while stalled")

   // A stalled response keeps its payload.
   `ASSERT_NEXT(rsp_payload_held, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_src_is_memory) && $stable(rsp_src_location) && $stable(rsp_dst_is_memory) && $stable(rsp_dst_location) && $stable(rsp_branch_offset) && $stable(rsp_read_value), "response payload changed while stalled")

   // Only one request is worked on at a time.
   `ASSERT_NEXT(one_in_work, clock, reset, req_valid && req_ready, !req_ready, "request taken while another is in work")

   // An operand in a register names one of the eight registers.
   `ASSERT_ALWAYS(reg_operand_range, clock, reset, !rsp_valid || ((rsp_src_is_memory || (rsp_src_location[15:3] == 13'd0)) && (rsp_dst_is_memory || (rsp_dst_location[15:3] == 13'd0))), "register operand out of range")

endmodule

bind operand_addressing_mode_unit oamu_chk u_oamu_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_src_is_memory (rsp_chan.src_is_memory),
   .rsp_src_location  (rsp_chan.src_location),
   .rsp_dst_is_memory (rsp_chan.dst_is_memory),
   .rsp_dst_location  (rsp_chan.dst_location),
   .rsp_branch_offset (rsp_chan.branch_offset),
   .rsp_read_value    (rsp_chan.read_value)
);

`default_nettype wire

>>> test/tb_operand_addressing_mode_unit.sv
// Self-checking testbench for the operand addressing mode unit, with its scoreboard class.

import oamu_pkg::*;

localparam int OAMU_MEMORY_WORDS = 4096;

class oamu_scoreboard;
   logic [15:0]  regs [8];
   logic [15:0]  words [OAMU_MEMORY_WORDS];
   bit           written [OAMU_MEMORY_WORDS];
   operand_type  src_opnd;
   operand_type  dst_opnd;
   logic [7:0]   branch_hold;
   rsp_item_type expected_responses [$];
   int           errors;
   // First word read before it was written during a decode, or -1.
   int           first_unwritten;

   function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (words[i]) begin
         words[i] = '0;
         written[i] = 1'b0;
      end
      src_opnd = '0;
      dst_opnd = '0;
      branch_hold = '0;
      errors = 0;
      first_unwritten = -1;
   endfunction

   function int word_slot(logic [15:0] addr);
      return int'(addr[15:1]) % OAMU_MEMORY_WORDS;
   endfunction

   function logic [15:0] fetch_word(logic [15:0] addr);
      int slot;
      slot = word_slot(addr);
      if (!written[slot] && first_unwritten < 0) first_unwritten = slot;
      return words[slot];
   endfunction

   // The index word sits at the program counter, which then moves past it.
   function logic [15:0] take_index_word();
      logic [15:0] w;
      w = fetch_word(regs[PC_REG]);
      regs[PC_REG] = regs[PC_REG] + 16'd2;
      return w;
   endfunction

   function operand_type resolve(logic [2:0] r, logic [2:0] mode, logic bmode);
      operand_type opnd;
      logic [15:0] step;
      logic [15:0] offset;
      step = (bmode && r < WORD_STEP_REG) ? 16'd1 : 16'd2;
      opnd.is_mem = 1'b1;
      opnd.loc = '0;
      case (mode)
         MODE_REG: begin
            opnd.is_mem = 1'b0;
            opnd.loc = {13'd0, r};
         end
         MODE_REG_DEF: opnd.loc = regs[r];
         MODE_AINC: begin
            opnd.loc = regs[r];
            regs[r] = regs[r] + step;
         end
         MODE_AINC_DEF: begin
            opnd.loc = fetch_word(regs[r]);
            regs[r] = regs[r] + 16'd2;
         end
         MODE_ADEC: begin
            regs[r] = regs[r] - step;
            opnd.loc = regs[r];
         end
         MODE_ADEC_DEF: begin
            regs[r] = regs[r] - 16'd2;
            opnd.loc = fetch_word(regs[r]);
         end
         MODE_INDEX: begin
            offset = take_index_word();
            opnd.loc = regs[r] + offset;
         end
         default: begin
            offset = take_index_word();
            opnd.loc = fetch_word(regs[r] + offset);
         end
      endcase
      return opnd;
   endfunction

   function void decode_operands(logic [15:0] op, logic [2:0] fmt, logic bmode);
      case (fmt)
         FMT_SSDD: begin
            src_opnd = resolve(op[8:6], op[11:9], bmode);
            dst_opnd = resolve(op[2:0], op[5:3], bmode);
         end
         FMT_DD: dst_opnd = resolve(op[2:0], op[5:3], bmode);
         FMT_BRANCH: branch_hold = op[7:0];
         FMT_REG_SS: begin
            src_opnd = resolve(op[2:0], op[5:3], bmode);
            dst_opnd = resolve(op[8:6], MODE_REG, bmode);
         end
         FMT_REG_DD: begin
            src_opnd = resolve(op[8:6], MODE_REG, bmode);
            dst_opnd = resolve(op[2:0], op[5:3], bmode);
         end
         FMT_REG: dst_opnd = resolve(op[2:0], MODE_REG, bmode);
         default: ;
      endcase
   endfunction

   // Runs a decode on the current state without keeping its effects and
   // returns the first memory word that it would read unwritten, or -1.
   function int trial_decode(req_item_type it);
      logic [15:0] saved_regs [8];
      operand_type saved_src;
      operand_type saved_dst;
      logic [7:0]  saved_branch;
      saved_regs = regs;
      saved_src = src_opnd;
      saved_dst = dst_opnd;
      saved_branch = branch_hold;
      first_unwritten = -1;
      decode_operands(it.opcode, it.instr_format, it.byte_mode);
      regs = saved_regs;
      src_opnd = saved_src;
      dst_opnd = saved_dst;
      branch_hold = saved_branch;
      return first_unwritten;
   endfunction

   function void note_request(req_item_type it);
      rsp_item_type rsp;
      int slot;
      rsp.read_value = '0;
      case (it.action)
         ACT_DECODE: decode_operands(it.opcode, it.instr_format, it.byte_mode);
         ACT_WRITE_REG: regs[it.target_register] = it.write_value;
         ACT_WRITE_MEM: begin
            slot = word_slot(it.write_address);
            words[slot] = it.write_value;
            written[slot] = 1'b1;
         end
         default: rsp.read_value = regs[it.target_register];
      endcase
      rsp.src_is_memory = src_opnd.is_mem;
      rsp.src_location = src_opnd.loc;
      rsp.dst_is_memory = dst_opnd.is_mem;
      rsp.dst_location = dst_opnd.loc;
      rsp.branch_offset = branch_hold;
      expected_responses.push_back(rsp);
   endfunction

   task report_mismatch(string what);
      if (errors < 50) $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
   endtask

   task check_response(rsp_item_type got);
      rsp_item_type want;
      if (expected_responses.size() == 0) begin
         report_mismatch($sformatf("response %h arrived with none outstanding", got));
         return;
      end
      want = expected_responses.pop_front();
      if (got.src_is_memory !== want.src_is_memory)
         report_mismatch($sformatf("src_is_memory %b, expected %b",
                                   got.src_is_memory, want.src_is_memory));
      if (got.src_location !== want.src_location)
         report_mismatch($sformatf("src_location %h, expected %h",
                                   got.src_location, want.src_location));
      if (got.dst_is_memory !== want.dst_is_memory)
         report_mismatch($sformatf("dst_is_memory %b, expected %b",
                                   got.dst_is_memory, want.dst_is_memory));
      if (got.dst_location !== want.dst_location)
         report_mismatch($sformatf("dst_location %h, expected %h",
                                   got.dst_location, want.dst_location));
      if (got.branch_offset !== want.branch_offset)
         report_mismatch($sformatf("branch_offset %h, expected %h",
                                   got.branch_offset, want.branch_offset));
      if (got.read_value !== want.read_value)
         report_mismatch($sformatf("read_value %h, expected %h",
                                   got.read_value, want.read_value));
   endtask
endclass

module tb_operand_addressing_mode_unit;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEM_TOTAL = 650;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam logic [2:0] FMT_NONE_LO = 3'd6;
   localparam logic [2:0] FMT_NONE_HI = 3'd7;

   logic clock;
   logic reset;

   oamu_req_if req_chan ();
   oamu_rsp_if rsp_chan ();

   operand_addressing_mode_unit #(.MEMORY_WORDS(OAMU_MEMORY_WORDS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   oamu_scoreboard sb;
   int sent_count;
   int sender_quiet;
   int receiver_quiet;
   bit hold_off_request;
   int hold_off_left;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mostly no gap, some short ones, a few long ones, and now and then a quiet stretch.
   function automatic int idle_length(inout int quiet_left);
      int pick;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         quiet_left = $urandom_range(20, 60);
         return 0;
      end
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic req_item_type random_fields();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[56:0];
   endfunction

   function automatic logic [15:0] two_operands(logic [2:0] src_mode, logic [2:0] src_reg,
                                                logic [2:0] dst_mode, logic [2:0] dst_reg);
      logic [15:0] w;
      w = 16'($urandom);
      w[11:0] = {src_mode, src_reg, dst_mode, dst_reg};
      return w;
   endfunction

   function automatic req_item_type decode_item(logic [2:0] fmt, logic bmode, logic [15:0] op);
      req_item_type it;
      it = random_fields();
      it.action = ACT_DECODE;
      it.instr_format = fmt;
      it.byte_mode = bmode;
      it.opcode = op;
      return it;
   endfunction

   function automatic req_item_type register_item(logic [1:0] act, logic [2:0] r,
                                                  logic [15:0] value);
      req_item_type it;
      it = random_fields();
      it.action = act;
      it.target_register = r;
      it.write_value = value;
      return it;
   endfunction

   function automatic req_item_type memory_item(logic [15:0] addr, logic [15:0] value);
      req_item_type it;
      it = random_fields();
      it.action = ACT_WRITE_MEM;
      it.write_address = addr;
      it.write_value = value;
      return it;
   endfunction

   function automatic logic [2:0] random_format();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) return FMT_SSDD;
      if (pick < 50) return FMT_DD;
      if (pick < 60) return FMT_BRANCH;
      if (pick < 70) return FMT_REG_SS;
      if (pick < 80) return FMT_REG_DD;
      if (pick < 90) return FMT_REG;
      if (pick < 95) return FMT_NONE_LO;
      return FMT_NONE_HI;
   endfunction

   // Register values that often point into the low memory window or near the wrap.
   function automatic logic [15:0] pointer_value();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return 16'($urandom);
      if (pick < 8) return 16'($urandom_range(0, 255));
      return 16'hFFFF - 16'($urandom_range(0, 7));
   endfunction

   task automatic drive_req(input req_item_type it);
      int gap;
      gap = (hold_off_request || hold_off_left > 0) ? 0 : idle_length(sender_quiet);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.action <= it.action;
      req_chan.opcode <= it.opcode;
      req_chan.instr_format <= it.instr_format;
      req_chan.byte_mode <= it.byte_mode;
      req_chan.target_register <= it.target_register;
      req_chan.write_address <= it.write_address;
      req_chan.write_value <= it.write_value;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      sb.note_request(it);
      sent_count++;
   endtask

   // Writes every memory word that the decode would read before it is written,
   // then sends the decode itself.
   task automatic send_decode(input req_item_type it);
      req_item_type fill;
      int slot;
      slot = sb.trial_decode(it);
      while (slot >= 0) begin
         fill = random_fields();
         fill.action = ACT_WRITE_MEM;
         fill.write_address[12:1] = slot[11:0];
         drive_req(fill);
         slot = sb.trial_decode(it);
      end
      drive_req(it);
   endtask

   task automatic run_directed();
      drive_req(register_item(ACT_READ_REG, 3'd0, 16'h0000));
      drive_req(register_item(ACT_WRITE_REG, 3'd0, 16'hFFFF));
      drive_req(register_item(ACT_WRITE_REG, 3'd1, 16'h0040));
      drive_req(register_item(ACT_WRITE_REG, 3'd6, 16'h0100));
      drive_req(memory_item(16'hFFFF, 16'hFFFF));
      drive_req(memory_item(16'h0000, 16'h0000));
      drive_req(register_item(ACT_READ_REG, 3'd0, 16'h1234));
      send_decode(decode_item(FMT_SSDD, 1'b0, two_operands(MODE_REG, 3'd0, MODE_REG_DEF, 3'd1)));
      // Byte steps: register 0 wraps up to zero, register 1 steps down by one.
      send_decode(decode_item(FMT_SSDD, 1'b1, two_operands(MODE_AINC, 3'd0, MODE_ADEC, 3'd1)));
      // Registers 6 and 7 step by a full word even in byte mode.
      send_decode(decode_item(FMT_SSDD, 1'b1, two_operands(MODE_AINC, 3'd6, MODE_ADEC, 3'd7)));
      send_decode(decode_item(FMT_DD, 1'b0, two_operands(MODE_REG, 3'd0, MODE_AINC_DEF, 3'd1)));
      send_decode(decode_item(FMT_DD, 1'b1, two_operands(MODE_REG, 3'd0, MODE_ADEC_DEF, 3'd2)));
      // Index off the program counter uses its advanced value as the base.
      send_decode(decode_item(FMT_SSDD, 1'b0,
                              two_operands(MODE_INDEX, 3'd7, MODE_INDEX_DEF, 3'd3)));
      send_decode(decode_item(FMT_REG_SS, 1'b0,
                              two_operands(MODE_REG, 3'd4, MODE_INDEX_DEF, 3'd7)));
      send_decode(decode_item(FMT_REG_DD, 1'b1, two_operands(MODE_REG, 3'd5, MODE_AINC, 3'd7)));
      send_decode(decode_item(FMT_REG, 1'b0, 16'hFFFF));
      send_decode(decode_item(FMT_BRANCH, 1'b0, 16'hA5FF));
      send_decode(decode_item(FMT_BRANCH, 1'b1, 16'hFF00));
      send_decode(decode_item(FMT_NONE_LO, 1'b0, 16'($urandom)));
      send_decode(decode_item(FMT_NONE_HI, 1'b1, 16'($urandom)));
      drive_req(register_item(ACT_READ_REG, 3'd7, 16'h0000));
      drive_req(register_item(ACT_READ_REG, 3'd6, 16'hFFFF));
      drive_req(register_item(ACT_READ_REG, 3'd2, 16'h0000));
   endtask

   task automatic send_random_item();
      req_item_type it;
      int pick;
      it = random_fields();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         it.action = ACT_DECODE;
         it.instr_format = random_format();
         send_decode(it);
      end else if (pick < 70) begin
         it.action = ACT_WRITE_REG;
         it.write_value = pointer_value();
         drive_req(it);
      end else if (pick < 85) begin
         it.action = ACT_WRITE_MEM;
         if ($urandom_range(0, 1) == 0) it.write_address = 16'($urandom_range(0, 511));
         drive_req(it);
      end else begin
         it.action = ACT_READ_REG;
         drive_req(it);
      end
   endtask

   initial begin : stimulus
      bit pressure_done;
      pressure_done = 1'b0;
      sb = new();
      sent_count = 0;
      sender_quiet = 0;
      hold_off_request = 1'b0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.action <= ACT_DECODE;
      req_chan.opcode <= '0;
      req_chan.instr_format <= FMT_SSDD;
      req_chan.byte_mode <= 1'b0;
      req_chan.target_register <= '0;
      req_chan.write_address <= '0;
      req_chan.write_value <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      while (sent_count < ITEM_TOTAL) begin
         // Halfway through, the receiver stops taking results for a long while.
         if (!pressure_done && sent_count >= ITEM_TOTAL / 2) begin
            hold_off_request = 1'b1;
            pressure_done = 1'b1;
         end
         send_random_item();
      end
      req_chan.valid <= 1'b0;
      while (sb.expected_responses.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin : response_side
      rsp_item_type got;
      int stall_left;
      stall_left = 0;
      receiver_quiet = 0;
      hold_off_left = 0;
      rsp_chan.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got.src_is_memory = rsp_chan.src_is_memory;
            got.src_location = rsp_chan.src_location;
            got.dst_is_memory = rsp_chan.dst_is_memory;
            got.dst_location = rsp_chan.dst_location;
            got.branch_offset = rsp_chan.branch_offset;
            got.read_value = rsp_chan.read_value;
            sb.check_response(got);
         end
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_off_left = HOLD_OFF_CYCLES;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall_left = idle_length(receiver_quiet);
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      wait (reset === 1'b0);
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
             (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("FAILURE");
      $finish;
   end
endmodule
